/* sv/rtcm3_frame_parser_crc24q_unit_macros.svh */
// ----------------------------------------------------------------------------
// rtcm3 framer assertion macros
// immediate-consequent and next-cycle forms for the port checker
// ----------------------------------------------------------------------------
`ifndef RTCM3_FRAME_PARSER_CRC24Q_UNIT_MACROS_SVH
`define RTCM3_FRAME_PARSER_CRC24Q_UNIT_MACROS_SVH

// consequent must hold in the same cycle
`define RTCM3FP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the following cycle
`define RTCM3FP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rtcm3fp_pkg.sv */
// ----------------------------------------------------------------------------
// rtcm3fp_pkg
// types, phase codes and crc-24q helper for the rtcm 3 framer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtcm3fp_pkg;

    localparam int BUFFER_BYTES_DEFAULT = 2048;
    localparam int CFG_W                = 12;
    localparam int CFG_MAX              = 4095;
    localparam int LEN_W                = 10;

    localparam logic [7:0]  RTCM_PREAMBLE = 8'hD3;
    localparam logic [24:0] CRC24Q_POLY   = 25'h1864CFB;

    localparam logic [3:0] PH_HUNT    = 4'd0;
    localparam logic [3:0] PH_LEN_HI  = 4'd1;
    localparam logic [3:0] PH_LEN_LO  = 4'd2;
    localparam logic [3:0] PH_PAYLOAD = 4'd3;
    localparam logic [3:0] PH_CRC1    = 4'd4;
    localparam logic [3:0] PH_CRC2    = 4'd5;
    localparam logic [3:0] PH_CRC3    = 4'd6;
    localparam logic [3:0] PH_DONE    = 4'd7;
    localparam logic [3:0] PH_STOP    = 4'd8;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [1:0] ACT_SKIP = 2'd0;
    localparam logic [1:0] ACT_SAVE = 2'd1;
    localparam logic [1:0] ACT_TERM = 2'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic        store_valid;
        logic [7:0]  store_byte;
        logic [10:0] store_offset;
        logic        nul_after;
        logic        frame_done;
        logic        crc_error;
        logic        overflow;
        logic [11:0] frame_total;
    } out_item_t;

    // msb-first crc-24q, one byte
    function automatic logic [23:0] crc24q_update(input logic [23:0] crc,
                                                  input logic [7:0]  b);
        logic [24:0] c;
        c = {1'b0, crc ^ {b, 16'h0000}};
        for (int i = 0; i < 8; i++) begin
            c = {c[23:0], 1'b0};
            if (c[24]) begin
                c = c ^ CRC24Q_POLY;
            end
        end
        return c[23:0];
    endfunction

endpackage

/* sv/rtcm3_frame_parser_crc24q_unit.sv */
// ----------------------------------------------------------------------------
// rtcm3_frame_parser_crc24q_unit
// rtcm 3 framer with crc-24q check and buffer store reporting
// ----------------------------------------------------------------------------
// Takes one byte (or a restart) per transfer and returns one result per
// transfer. Its result appears in the cycle after the transfer, and a new
// input is taken in every cycle in which the result register is empty or
// being drained, so the sustained rate is one item per clock. The single
// stage holds the byte-wide crc-24q update and the phase, length and buffer
// space bookkeeping. The capacity register is sampled when a preamble starts
// a frame; writes to it are always accepted.
`timescale 1ns / 1ps

module rtcm3_frame_parser_crc24q_unit #(
    parameter int BUFFER_BYTES = rtcm3fp_pkg::BUFFER_BYTES_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  rtcm3fp_pkg::in_item_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rtcm3fp_pkg::out_item_t m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [11:0]            cfg_data
);
    import rtcm3fp_pkg::*;

    localparam int CAP_MAX = (BUFFER_BYTES > CFG_MAX) ? BUFFER_BYTES : CFG_MAX;
    localparam int SPACE_W = $clog2(CAP_MAX + 1);
    localparam logic [SPACE_W-1:0] BB_VAL = SPACE_W'(BUFFER_BYTES);
    localparam logic [SPACE_W-1:0] ONE    = SPACE_W'(1);
    localparam logic [SPACE_W-1:0] TWO    = SPACE_W'(2);

    logic [SPACE_W-1:0] capacity_reg;
    logic [3:0]         phase_reg,  phase_next;
    logic [23:0]        crc_reg,    crc_next;
    logic [LEN_W-1:0]   len_reg,    len_next;
    logic [SPACE_W-1:0] space_reg,  space_next;
    logic [SPACE_W-1:0] wofs_reg,   wofs_next;
    logic               err_reg,    err_next;
    logic               m_valid_reg;
    out_item_t          m_data_reg, m_data_next;

    logic               accept;
    logic [1:0]         action;
    logic               mismatch;
    logic [7:0]         expect_byte;
    logic [7:0]         b;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign b         = s_data.data_byte;

    always_comb begin
        unique case (phase_reg)
            PH_CRC1: expect_byte = crc_reg[23:16];
            PH_CRC2: expect_byte = crc_reg[15:8];
            default: expect_byte = crc_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        len_next    = len_reg;
        space_next  = space_reg;
        wofs_next   = wofs_reg;
        err_next    = err_reg;
        action      = ACT_SKIP;
        mismatch    = 1'b0;
        m_data_next = '0;

        if (s_data.op == OP_RESTART) begin
            phase_next = PH_HUNT;
        end else begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (b == RTCM_PREAMBLE) begin
                        space_next = (capacity_reg > BB_VAL) ? BB_VAL : capacity_reg;
                        wofs_next  = '0;
                        len_next   = '0;
                        err_next   = 1'b0;
                        crc_next   = crc24q_update(24'h000000, b);
                        phase_next = PH_LEN_HI;
                        action     = ACT_SAVE;
                    end
                end
                PH_LEN_HI: begin
                    crc_next   = crc24q_update(crc_reg, b);
                    len_next   = {b[1:0], 8'h00};
                    phase_next = PH_LEN_LO;
                    action     = ACT_SAVE;
                end
                PH_LEN_LO: begin
                    crc_next   = crc24q_update(crc_reg, b);
                    len_next   = {len_reg[9:8], len_reg[7:0] | b};
                    phase_next = (len_next != '0) ? PH_PAYLOAD : PH_CRC1;
                    action     = ACT_SAVE;
                end
                PH_PAYLOAD: begin
                    crc_next = crc24q_update(crc_reg, b);
                    if (len_reg > LEN_W'(1)) begin
                        len_next = len_reg - LEN_W'(1);
                    end else begin
                        len_next   = '0;
                        phase_next = PH_CRC1;
                    end
                    action = ACT_SAVE;
                end
                PH_CRC1, PH_CRC2, PH_CRC3: begin
                    if (b != expect_byte) begin
                        mismatch   = 1'b1;
                        err_next   = 1'b1;
                        phase_next = PH_STOP;
                        action     = ACT_TERM;
                    end else if (phase_reg == PH_CRC3) begin
                        phase_next = PH_DONE;
                        action     = ACT_TERM;
                    end else begin
                        phase_next = phase_reg + 4'd1;
                        action     = ACT_SAVE;
                    end
                end
                default: begin
                end
            endcase

            if (action == ACT_SAVE) begin
                if (space_next != '0) begin
                    m_data_next.store_valid  = 1'b1;
                    m_data_next.store_byte   = b;
                    m_data_next.store_offset = wofs_next[10:0];
                    wofs_next  = wofs_next + ONE;
                    space_next = space_next - ONE;
                end else begin
                    phase_next           = PH_STOP;
                    m_data_next.overflow = 1'b1;
                end
            end else if (action == ACT_TERM) begin
                if (space_next > ONE) begin
                    m_data_next.store_valid  = 1'b1;
                    m_data_next.store_byte   = b;
                    m_data_next.store_offset = wofs_next[10:0];
                    m_data_next.nul_after    = 1'b1;
                    wofs_next  = wofs_next + TWO;
                    space_next = space_next - TWO;
                    if (!mismatch) begin
                        m_data_next.frame_done  = 1'b1;
                        m_data_next.frame_total = wofs_next[11:0];
                    end
                end else begin
                    phase_next           = PH_STOP;
                    m_data_next.overflow = !mismatch;
                end
            end
        end

        m_data_next.phase     = phase_next;
        m_data_next.crc_error = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= BB_VAL;
            phase_reg    <= PH_HUNT;
            crc_reg      <= '0;
            len_reg      <= '0;
            space_reg    <= '0;
            wofs_reg     <= '0;
            err_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= SPACE_W'(cfg_data);
            end
            if (accept) begin
                phase_reg <= phase_next;
                crc_reg   <= crc_next;
                len_reg   <= len_next;
                space_reg <= space_next;
                wofs_reg  <= wofs_next;
                err_reg   <= err_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

/* sv/rtcm3fp_checker.sv */
// ----------------------------------------------------------------------------
// rtcm3fp_checker
// port-level checks on the rtcm 3 framer result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rtcm3_frame_parser_crc24q_unit_macros.svh"

module rtcm3fp_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input rtcm3fp_pkg::out_item_t m_data
);
    import rtcm3fp_pkg::*;

    // stalled result holds
    `RTCM3FP_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // every input transfer yields a result next cycle
    `RTCM3FP_ASSERT_NEXT(a_result, aclk, aresetn, s_valid && s_ready, m_valid, "input transfer gave no result")

    `RTCM3FP_ASSERT_SAME(a_done, aclk, aresetn, m_valid && m_data.frame_done, m_data.store_valid && m_data.nul_after && (m_data.phase == PH_DONE) && !m_data.crc_error, "frame end without terminator store")

    `RTCM3FP_ASSERT_SAME(a_ovf, aclk, aresetn, m_valid && m_data.overflow, (m_data.phase == PH_STOP) && !m_data.store_valid && !m_data.frame_done, "overflow without stop")

    `RTCM3FP_ASSERT_SAME(a_idle_fields, aclk, aresetn, m_valid && !m_data.store_valid, (m_data.store_byte == 8'h00) && (m_data.store_offset == 11'h000) && !m_data.nul_after, "store fields set without store")

endmodule

bind rtcm3_frame_parser_crc24q_unit rtcm3fp_checker u_rtcm3fp_checker (.*);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rtcm 3 framer with crc-24q check. Frames are
// built here with their crc, optionally corrupted, cut short by a restart or
// squeezed by a small buffer capacity, and each byte is run through a local
// model of the framer; every result transfer is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import rtcm3fp_pkg::*;

    localparam int          CYCLE_LIMIT = 100000;
    localparam int          REPORT_MAX  = 40;
    localparam logic [11:0] BUF_LIMIT   = 12'(BUFFER_BYTES_DEFAULT);

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [11:0] cfg_data  = '0;

    // framer model state
    logic [11:0] cap_reg    = BUF_LIMIT;
    logic [3:0]  ph         = PH_HUNT;
    logic [23:0] crc_acc    = '0;
    logic [9:0]  len_left   = '0;
    logic [11:0] space_left = '0;
    logic [11:0] wr_off     = '0;
    logic        err_flag   = 1'b0;

    out_item_t   results_due[$];

    int          tx_idle_pct   = 0;
    int          rx_idle_pct   = 0;
    int          fail_count    = 0;
    int          items_sent    = 0;
    int          active_items  = 0;
    int          frames_done   = 0;
    int          crc_errors    = 0;
    int          overflows     = 0;
    int          cap_writes    = 0;
    int unsigned cycle_count   = 0;

    rtcm3_frame_parser_crc24q_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     results_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [23:0] crc24q_next(input logic [23:0] acc, input logic [7:0] b);
        logic [23:0] c;
        c = acc ^ {b, 16'h0000};
        for (int k = 0; k < 8; k++) begin
            c = c[23] ? ({c[22:0], 1'b0} ^ CRC24Q_POLY[23:0]) : {c[22:0], 1'b0};
        end
        return c;
    endfunction

    // advances the framer model by one transfer and returns its result
    function automatic out_item_t parse_byte(input in_item_t it);
        out_item_t  r;
        logic [1:0] act;
        logic       bad;
        logic [7:0] want;
        r   = '0;
        act = ACT_SKIP;
        bad = 1'b0;
        if (it.op == OP_RESTART) begin
            ph = PH_HUNT;
        end else begin
            case (ph)
                PH_HUNT: begin
                    if (it.data_byte == RTCM_PREAMBLE) begin
                        space_left = (cap_reg > BUF_LIMIT) ? BUF_LIMIT : cap_reg;
                        wr_off     = '0;
                        len_left   = '0;
                        err_flag   = 1'b0;
                        crc_acc    = crc24q_next(24'h000000, it.data_byte);
                        ph         = PH_LEN_HI;
                        act        = ACT_SAVE;
                    end
                end
                PH_LEN_HI: begin
                    crc_acc  = crc24q_next(crc_acc, it.data_byte);
                    len_left = {it.data_byte[1:0], 8'h00};
                    ph       = PH_LEN_LO;
                    act      = ACT_SAVE;
                end
                PH_LEN_LO: begin
                    crc_acc  = crc24q_next(crc_acc, it.data_byte);
                    len_left = {len_left[9:8], it.data_byte};
                    ph       = (len_left != 0) ? PH_PAYLOAD : PH_CRC1;
                    act      = ACT_SAVE;
                end
                PH_PAYLOAD: begin
                    crc_acc = crc24q_next(crc_acc, it.data_byte);
                    if (len_left > 1) begin
                        len_left = len_left - 10'd1;
                    end else begin
                        len_left = '0;
                        ph       = PH_CRC1;
                    end
                    act = ACT_SAVE;
                end
                PH_CRC1, PH_CRC2, PH_CRC3: begin
                    want = (ph == PH_CRC1) ? crc_acc[23:16] :
                           (ph == PH_CRC2) ? crc_acc[15:8] : crc_acc[7:0];
                    if (it.data_byte != want) begin
                        bad      = 1'b1;
                        err_flag = 1'b1;
                        ph       = PH_STOP;
                        act      = ACT_TERM;
                    end else if (ph == PH_CRC3) begin
                        ph  = PH_DONE;
                        act = ACT_TERM;
                    end else begin
                        ph  = ph + 4'd1;
                        act = ACT_SAVE;
                    end
                end
                default: ;
            endcase

            if (act == ACT_SAVE) begin
                if (space_left > 0) begin
                    r.store_valid  = 1'b1;
                    r.store_byte   = it.data_byte;
                    r.store_offset = wr_off[10:0];
                    wr_off         = wr_off + 12'd1;
                    space_left     = space_left - 12'd1;
                end else begin
                    ph         = PH_STOP;
                    r.overflow = 1'b1;
                end
            end else if (act == ACT_TERM) begin
                if (space_left > 1) begin
                    r.store_valid  = 1'b1;
                    r.store_byte   = it.data_byte;
                    r.store_offset = wr_off[10:0];
                    r.nul_after    = 1'b1;
                    wr_off         = wr_off + 12'd2;
                    space_left     = space_left - 12'd2;
                    if (!bad) begin
                        r.frame_done  = 1'b1;
                        r.frame_total = wr_off;
                    end
                end else begin
                    ph         = PH_STOP;
                    r.overflow = !bad;
                end
            end
        end
        r.phase     = ph;
        r.crc_error = err_flag;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < REPORT_MAX) begin
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        end
        fail_count++;
    endtask

    // result channel: random stalls and comparison against the model
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("result with nothing pending", int'(m_data.phase), 0);
            end else begin
                want = results_due.pop_front();
                if (m_data.phase !== want.phase)
                    report_mismatch("phase", int'(m_data.phase), int'(want.phase));
                if (m_data.store_valid !== want.store_valid)
                    report_mismatch("store_valid", int'(m_data.store_valid),
                                    int'(want.store_valid));
                if (m_data.store_byte !== want.store_byte)
                    report_mismatch("store_byte", int'(m_data.store_byte),
                                    int'(want.store_byte));
                if (m_data.store_offset !== want.store_offset)
                    report_mismatch("store_offset", int'(m_data.store_offset),
                                    int'(want.store_offset));
                if (m_data.nul_after !== want.nul_after)
                    report_mismatch("nul_after", int'(m_data.nul_after),
                                    int'(want.nul_after));
                if (m_data.frame_done !== want.frame_done)
                    report_mismatch("frame_done", int'(m_data.frame_done),
                                    int'(want.frame_done));
                if (m_data.crc_error !== want.crc_error)
                    report_mismatch("crc_error", int'(m_data.crc_error),
                                    int'(want.crc_error));
                if (m_data.overflow !== want.overflow)
                    report_mismatch("overflow", int'(m_data.overflow),
                                    int'(want.overflow));
                if (m_data.frame_total !== want.frame_total)
                    report_mismatch("frame_total", int'(m_data.frame_total),
                                    int'(want.frame_total));
            end
        end
    end

    // one input transfer, with random idle cycles in front of it
    task automatic send_item(input logic op, input logic [7:0] b);
        in_item_t  it;
        out_item_t r;
        logic      ignored;
        it.op        = op;
        it.data_byte = b;
        @(negedge aclk);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        ignored = (op == OP_BYTE) && ((ph == PH_HUNT && b != RTCM_PREAMBLE) ||
                                      ph == PH_DONE || ph == PH_STOP);
        r = parse_byte(it);
        results_due.push_back(r);
        items_sent++;
        if (!ignored)
            active_items++;
        frames_done += int'(r.frame_done);
        overflows   += int'(r.overflow);
        if (r.crc_error && r.phase == PH_STOP && r.store_valid | !r.overflow && !ignored)
            crc_errors += int'((it.op == OP_BYTE) && (r.phase == PH_STOP) && !r.overflow);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [11:0] value);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cap_reg = value;
        cap_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // restart, then a frame of len payload bytes; bad_crc picks a crc byte to
    // corrupt, cut_at a position where a restart replaces the byte
    task automatic send_frame(input int len, input int bad_crc, input int cut_at,
                              input int fill);
        logic [7:0]  frame_bytes[$];
        logic [9:0]  l;
        logic [7:0]  hi;
        logic [23:0] c;
        l      = 10'(len);
        hi     = 8'($urandom);
        hi[1:0] = l[9:8];
        frame_bytes = {RTCM_PREAMBLE, hi, l[7:0]};
        for (int i = 0; i < len; i++) begin
            frame_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        end
        c = '0;
        foreach (frame_bytes[i]) c = crc24q_next(c, frame_bytes[i]);
        frame_bytes.push_back(c[23:16]);
        frame_bytes.push_back(c[15:8]);
        frame_bytes.push_back(c[7:0]);
        if (bad_crc >= 0) begin
            frame_bytes[len + 3 + bad_crc] ^= 8'($urandom_range(255, 1));
        end
        send_item(OP_RESTART, 8'($urandom));
        for (int i = 0; i < frame_bytes.size(); i++) begin
            if (i == cut_at) begin
                send_item(OP_RESTART, 8'($urandom));
                break;
            end
            send_item(OP_BYTE, frame_bytes[i]);
        end
    endtask

    task automatic test_empty_frame();
        send_frame(0, -1, -1, -1);
        // bytes after a finished frame are ignored
        send_item(OP_BYTE, RTCM_PREAMBLE);
    endtask

    task automatic test_crc_mismatch();
        send_frame(1, 1, -1, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        // error survives a restart, cleared by the next preamble
        send_item(OP_RESTART, 8'hFF);
        send_item(OP_BYTE, RTCM_PREAMBLE);
        send_item(OP_RESTART, 8'h00);
    endtask

    task automatic test_last_byte_overflow();
        write_capacity(12'd6);
        send_frame(0, -1, -1, -1);
    endtask

    task automatic test_zero_capacity();
        write_capacity(12'd0);
        send_item(OP_RESTART, 8'h00);
        send_item(OP_BYTE, RTCM_PREAMBLE);
    endtask

    task automatic test_random_frames(input int n_items);
        int target;
        int frames;
        int len;
        int bad;
        int cut;
        target = active_items + n_items;
        frames = 0;
        while (active_items < target) begin
            if (frames % 6 == 0) begin
                case ($urandom_range(9, 0))
                    0, 1, 2, 3, 4: write_capacity(BUF_LIMIT);
                    5:             write_capacity(12'($urandom_range(4095, 2049)));
                    6, 7, 8:       write_capacity(12'($urandom_range(30, 0)));
                    default:       write_capacity(12'($urandom_range(2047, 0)));
                endcase
            end
            len = ($urandom_range(9, 0) == 0) ? int'($urandom_range(64, 17))
                                               : int'($urandom_range(16, 0));
            bad = ($urandom_range(99, 0) < 15) ? int'($urandom_range(2, 0)) : -1;
            cut = ($urandom_range(99, 0) < 10) ? int'($urandom_range(len + 5, 0)) : -1;
            if ($urandom_range(4, 0) == 0)
                repeat ($urandom_range(3, 1)) send_item(OP_BYTE, 8'($urandom));
            send_frame(len, bad, cut, -1);
            if ($urandom_range(6, 0) == 0)
                send_item(OP_BYTE, 8'($urandom));
            frames++;
        end
    endtask

    task automatic test_long_frame();
        // capacity above the buffer size is clamped
        write_capacity(12'hFFF);
        send_frame(1023, -1, -1, -1);
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 10;
        rx_idle_pct = 88;
        test_empty_frame();
        test_crc_mismatch();
        test_last_byte_overflow();
        test_zero_capacity();
        test_random_frames(250);

        tx_idle_pct = 88;
        rx_idle_pct = 10;
        test_random_frames(250);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_frames(250);
        test_long_frame();

        settle();
        $display("sent %0d transfers (%0d not ignored) over %0d capacity settings",
                 items_sent, active_items, cap_writes);
        $display("frames done %0d, crc stops %0d, overflow stops %0d, mismatches %0d",
                 frames_done, crc_errors, overflows, fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
